>>> rtl/core/bitmap_frame_allocator_macros.svh
// Assertion macros for the bitmap frame allocator.
// Used by the top level only; no dependencies.
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BFA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bfa_pkg.sv
// Shared types, constants and helpers for the bitmap frame allocator.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

   localparam int FRAME_COUNT = 4096;
   localparam int WORD_W      = 32;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int MAP_WORDS   = FRAME_COUNT / WORD_W;
   localparam int ADDR_W      = $clog2(MAP_WORDS);
   localparam int FRAME_W     = 12;
   localparam int FIELD_WORDS = 4096 / WORD_W;
   localparam int SCAN_MAX    = (MAP_WORDS < FIELD_WORDS) ? MAP_WORDS : FIELD_WORDS;
   localparam int CNT_W       = $clog2(SCAN_MAX + 1);
   localparam int LIMIT_W     = 13;
   localparam int STATUS_W    = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
   localparam logic [WORD_W-1:0]  WORD_FULL   = {WORD_W{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      STAT_ALLOCATED = 3'd0,
      STAT_HELD      = 3'd1,
      STAT_NO_FREE   = 3'd2,
      STAT_FREED     = 3'd3,
      STAT_NONE      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE
   } state_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   // Write port of the usage map store.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } map_wr_type;

   // Position of the lowest clear bit; only meaningful when the word is not full.
   function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] onehot;
      logic [BIT_W-1:0]  pos;
      onehot = ~word & (word + WORD_W'(1));
      pos    = '0;
      for (int b = 0; b < WORD_W; b++) begin
         if (onehot[b]) begin
            pos = pos | BIT_W'(b);
         end
      end
      return pos;
   endfunction

endpackage

>>> rtl/core/bfa_map_store.sv
// Usage map store: one synchronous memory word per 32 frames, one read and one write port.
// Per-word valid flags make unwritten words read as zero after reset. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_map_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [bfa_pkg::ADDR_W-1:0]     rd_addr,
   output logic [bfa_pkg::WORD_W-1:0]     rd_data,
   input  bfa_pkg::map_wr_type            wr
);

   logic [bfa_pkg::WORD_W-1:0]    mem [bfa_pkg::MAP_WORDS];
   logic [bfa_pkg::MAP_WORDS-1:0] valid_ff;
   logic [bfa_pkg::WORD_W-1:0]    rdata_ff;
   logic                          rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Words never written since reset read as all frames free.
   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

>>> rtl/core/bitmap_frame_allocator.sv
// Top level of the first-fit bitmap frame allocator.
// Depends on bfa_pkg, bfa_map_store and bitmap_frame_allocator_macros.svh.
`timescale 1ns / 1ps
`include "bitmap_frame_allocator_macros.svh"

// Usage:
//   A request is taken at a rising edge with start high and busy low. It carries
//   req_action (allocate or free), req_entry_frame and the page flags.
//   Every request yields exactly one result on the rsp_ ports, marked by
//   rsp_strobe for one cycle; the receiver must take it then, it cannot stall.
//   The frame limit is written through csr_valid/csr_ready/csr_data while idle.
// Sequence:
//   Held, nothing-to-free and limit-below-32 cases: result in the cycle after accept.
//   Free: a read-modify-write of one map word; ST_FREE writes it and sets the result.
//   Allocate: the scan reads one map word per cycle from word 0 up through the
//   single read port of the map memory and checks each word after its registered
//   read; it ends at the first word with a clear bit, or with no free frame after W
//   words, W = min(limit/32, 128). busy stays high until the result cycle,
//   so the next request can be taken at the edge that takes the result.
// Reset:
//   Synchronous, active high. The map reads as all free right after reset
//   through per-word valid flags; no clearing pass. The limit returns to 4096.

module bitmap_frame_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [bfa_pkg::FRAME_W-1:0]         req_entry_frame,
   input  logic                                req_is_kernel,
   input  logic                                req_is_writeable,
   output logic                                rsp_strobe,
   output logic [bfa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bfa_pkg::FRAME_W-1:0]         rsp_frame_number,
   output logic                                rsp_present,
   output logic                                rsp_writable,
   output logic                                rsp_user_mode,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bfa_pkg::LIMIT_W-1:0]         csr_data
);

   bfa_pkg::state_type              state_ff, state_in;
   logic [bfa_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic                            pend_ff, pend_in;
   logic [bfa_pkg::ADDR_W-1:0]      raddr_ff, raddr_in;
   logic [bfa_pkg::FRAME_W-1:0]     entry_ff, entry_in;
   logic                            kern_ff, kern_in;
   logic                            wr_ff, wr_in;
   logic [bfa_pkg::LIMIT_W-1:0]     limit_ff, limit_in;

   logic                            strobe_ff, strobe_in;
   bfa_pkg::status_type             status_ff, status_in;
   logic [bfa_pkg::FRAME_W-1:0]     fnum_ff, fnum_in;
   logic                            pres_ff, pres_in;
   logic                            rw_ff, rw_in;
   logic                            usr_ff, usr_in;

   logic                            accept;
   logic [bfa_pkg::CNT_W-1:0]       words;
   logic [bfa_pkg::LIMIT_W-bfa_pkg::BIT_W-1:0] lim_words;
   logic                            rd_en;
   logic [bfa_pkg::ADDR_W-1:0]      rd_addr;
   logic [bfa_pkg::WORD_W-1:0]      rd_data;
   bfa_pkg::map_wr_type             map_wr;
   logic [bfa_pkg::BIT_W-1:0]       free_bit;
   logic                            hit;

   assign accept    = start && !busy;
   assign busy      = (state_ff != bfa_pkg::ST_IDLE);
   assign csr_ready = !busy;

   // Whole words only, clamped to the map.
   assign lim_words = limit_ff[bfa_pkg::LIMIT_W-1:bfa_pkg::BIT_W];
   assign words     = (lim_words > (bfa_pkg::LIMIT_W-bfa_pkg::BIT_W)'(bfa_pkg::SCAN_MAX))
                      ? bfa_pkg::CNT_W'(bfa_pkg::SCAN_MAX)
                      : bfa_pkg::CNT_W'(lim_words);

   assign free_bit = bfa_pkg::lowest_zero(rd_data);
   assign hit      = pend_ff && (rd_data != bfa_pkg::WORD_FULL);

   bfa_map_store u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (map_wr)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == bfa_pkg::ACT_ALLOC) begin
                  if (req_entry_frame == '0 && words != '0) begin
                     state_in = bfa_pkg::ST_SCAN;
                  end
               end else if (req_entry_frame != '0) begin
                  state_in = bfa_pkg::ST_FREE;
               end
            end
         end
         bfa_pkg::ST_SCAN: begin
            if (hit || idx_ff >= words) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end
         bfa_pkg::ST_FREE: begin
            state_in = bfa_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfa_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, memory controls and result words.
   always_comb begin
      idx_in    = idx_ff;
      pend_in   = 1'b0;
      raddr_in  = raddr_ff;
      entry_in  = entry_ff;
      kern_in   = kern_ff;
      wr_in     = wr_ff;
      limit_in  = limit_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[bfa_pkg::ADDR_W-1:0];
      map_wr.en   = 1'b0;
      map_wr.addr = raddr_ff;
      map_wr.data = rd_data;
      strobe_in = 1'b0;
      status_in = status_ff;
      fnum_in   = fnum_ff;
      pres_in   = pres_ff;
      rw_in     = rw_ff;
      usr_in    = usr_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end

      case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (accept) begin
               entry_in = req_entry_frame;
               kern_in  = req_is_kernel;
               wr_in    = req_is_writeable;
               idx_in   = '0;
               if (req_action == bfa_pkg::ACT_ALLOC) begin
                  if (req_entry_frame != '0) begin
                     strobe_in = 1'b1;
                     status_in = bfa_pkg::STAT_HELD;
                     fnum_in   = req_entry_frame;
                     pres_in   = 1'b0;
                     rw_in     = 1'b0;
                     usr_in    = 1'b0;
                  end else if (words == '0) begin
                     strobe_in = 1'b1;
                     status_in = bfa_pkg::STAT_NO_FREE;
                     fnum_in   = '0;
                     pres_in   = 1'b0;
                     rw_in     = 1'b0;
                     usr_in    = 1'b0;
                  end
               end else if (req_entry_frame == '0) begin
                  strobe_in = 1'b1;
                  status_in = bfa_pkg::STAT_NONE;
                  fnum_in   = '0;
                  pres_in   = 1'b0;
                  rw_in     = 1'b0;
                  usr_in    = 1'b0;
               end else begin
                  // fetch the word that holds the frame
                  rd_en   = 1'b1;
                  rd_addr = req_entry_frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
               end
            end
         end
         bfa_pkg::ST_SCAN: begin
            if (hit) begin
               // set the lowest clear bit; no further word is read
               map_wr.en   = 1'b1;
               map_wr.addr = raddr_ff;
               map_wr.data = rd_data | (bfa_pkg::WORD_W'(1) << free_bit);
               strobe_in   = 1'b1;
               status_in   = bfa_pkg::STAT_ALLOCATED;
               fnum_in     = {raddr_ff, free_bit};
               pres_in     = 1'b1;
               rw_in       = wr_ff;
               usr_in      = !kern_ff;
            end else if (idx_ff < words) begin
               // advance: one word read per cycle, checked in the cycle after its read
               rd_en    = 1'b1;
               rd_addr  = idx_ff[bfa_pkg::ADDR_W-1:0];
               raddr_in = idx_ff[bfa_pkg::ADDR_W-1:0];
               idx_in   = idx_ff + bfa_pkg::CNT_W'(1);
               pend_in  = 1'b1;
            end else begin
               strobe_in = 1'b1;
               status_in = bfa_pkg::STAT_NO_FREE;
               fnum_in   = '0;
               pres_in   = 1'b0;
               rw_in     = 1'b0;
               usr_in    = 1'b0;
            end
         end
         bfa_pkg::ST_FREE: begin
            map_wr.en   = 1'b1;
            map_wr.addr = entry_ff[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
            map_wr.data = rd_data & ~(bfa_pkg::WORD_W'(1) << entry_ff[bfa_pkg::BIT_W-1:0]);
            strobe_in   = 1'b1;
            status_in   = bfa_pkg::STAT_FREED;
            fnum_in     = '0;
            pres_in     = 1'b0;
            rw_in       = 1'b0;
            usr_in      = 1'b0;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bfa_pkg::ST_IDLE;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         limit_ff  <= bfa_pkg::LIMIT_RESET;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
         limit_ff  <= limit_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff  <= raddr_in;
      entry_ff  <= entry_in;
      kern_ff   <= kern_in;
      wr_ff     <= wr_in;
      status_ff <= status_in;
      fnum_ff   <= fnum_in;
      pres_ff   <= pres_in;
      rw_ff     <= rw_in;
      usr_ff    <= usr_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_frame_number = fnum_ff;
   assign rsp_present      = pres_ff;
   assign rsp_writable     = rw_ff;
   assign rsp_user_mode    = usr_ff;

   `BFA_ASSERT_NXT(a_accept_progress, clock, reset, accept, (busy || rsp_strobe),
                   "accepted request neither started nor answered")
   `BFA_ASSERT_IMP(a_scan_bound, clock, reset, (state_ff == bfa_pkg::ST_SCAN),
                   (idx_ff <= words), "scan index ran past the limit")
   `BFA_ASSERT_IMP(a_flags_alloc_only, clock, reset,
                   (rsp_strobe && rsp_status != bfa_pkg::STAT_ALLOCATED),
                   (!rsp_present && !rsp_writable && !rsp_user_mode),
                   "entry flags set outside allocation")

endmodule

>>> dv/bitmap_frame_allocator_tb.sv
// Self-checking testbench for the first-fit bitmap frame allocator.
// Drives requests and frame-limit writes, predicts every result in place.
// Depends on bfa_pkg and the bitmap_frame_allocator top level.
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      bfa_pkg::status_type         status;
      logic [bfa_pkg::FRAME_W-1:0] frame;
      logic                        present;
      logic                        writable;
      logic                        user_mode;
   } grant_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_action;
   logic [bfa_pkg::FRAME_W-1:0]  req_entry_frame;
   logic                         req_is_kernel;
   logic                         req_is_writeable;
   logic                         rsp_strobe;
   logic [bfa_pkg::STATUS_W-1:0] rsp_status;
   logic [bfa_pkg::FRAME_W-1:0]  rsp_frame_number;
   logic                         rsp_present;
   logic                         rsp_writable;
   logic                         rsp_user_mode;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [bfa_pkg::LIMIT_W-1:0]  csr_data;

   // Shadow of the usage map and the frame limit.
   logic [bfa_pkg::WORD_W-1:0]   frame_map [bfa_pkg::MAP_WORDS];
   logic [bfa_pkg::LIMIT_W-1:0]  limit_model;

   grant_type                    pending_grants [$];
   logic [bfa_pkg::FRAME_W-1:0]  owned_frames [$];
   grant_type                    want;

   int                  errors;
   int                  cycle_count;
   int                  requests;
   int                  limit_writes;
   int                  tally [5];
   int                  burst_left;
   bit                  start_high;

   bitmap_frame_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_entry_frame  (req_entry_frame),
      .req_is_kernel    (req_is_kernel),
      .req_is_writeable (req_is_writeable),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_frame_number (rsp_frame_number),
      .rsp_present      (rsp_present),
      .rsp_writable     (rsp_writable),
      .rsp_user_mode    (rsp_user_mode),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Predicted result of a request; allocation is first-fit over the whole words below the limit.
   function automatic grant_type predict_grant(bfa_pkg::action_type act,
                                               logic [bfa_pkg::FRAME_W-1:0] entry,
                                               logic kern, logic wr);
      grant_type g;
      int        words;
      int        f;
      g = '0;
      f = -1;
      if (act == bfa_pkg::ACT_ALLOC) begin
         if (entry != '0) begin
            g.status = bfa_pkg::STAT_HELD;
            g.frame  = entry;
         end else begin
            words = int'(limit_model) / bfa_pkg::WORD_W;
            if (words > bfa_pkg::MAP_WORDS) words = bfa_pkg::MAP_WORDS;
            if (words > bfa_pkg::FIELD_WORDS) words = bfa_pkg::FIELD_WORDS;
            for (int i = 0; i < words && f < 0; i++) begin
               for (int b = 0; b < bfa_pkg::WORD_W && f < 0; b++) begin
                  if (!frame_map[i][b]) f = i * bfa_pkg::WORD_W + b;
               end
            end
            if (f >= 0) begin
               frame_map[f / bfa_pkg::WORD_W][f % bfa_pkg::WORD_W] = 1'b1;
               g.status    = bfa_pkg::STAT_ALLOCATED;
               g.frame     = bfa_pkg::FRAME_W'(f);
               g.present   = 1'b1;
               g.writable  = wr;
               g.user_mode = ~kern;
            end else begin
               g.status = bfa_pkg::STAT_NO_FREE;
            end
         end
      end else if (entry == '0) begin
         g.status = bfa_pkg::STAT_NONE;
      end else begin
         // Clear even when not set.
         if (int'(entry) / bfa_pkg::WORD_W < bfa_pkg::MAP_WORDS) begin
            frame_map[int'(entry) / bfa_pkg::WORD_W][int'(entry) % bfa_pkg::WORD_W] = 1'b0;
         end
         g.status = bfa_pkg::STAT_FREED;
      end
      return g;
   endfunction

   task automatic check_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_grants.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual status %0d frame %0d",
                     $time, rsp_status, rsp_frame_number);
         end else begin
            want = pending_grants.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("frame_number", want.frame, rsp_frame_number);
            check_field("present", want.present, rsp_present);
            check_field("writable", want.writable, rsp_writable);
            check_field("user_mode", want.user_mode, rsp_user_mode);
         end
      end
   end

   task automatic wait_results_drained();
      do @(posedge clock); while (pending_grants.size() != 0);
   endtask

   // Drop start and scramble the fields while the sender rests.
   task automatic hold_sender();
      if (start_high) begin
         start            <= 1'b0;
         req_entry_frame  <= bfa_pkg::FRAME_W'($urandom);
         req_action       <= 1'($urandom);
         start_high = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic issue(bfa_pkg::action_type act, logic [bfa_pkg::FRAME_W-1:0] entry,
                        logic kern, logic wr);
      grant_type g;
      start            <= 1'b1;
      req_action       <= act;
      req_entry_frame  <= entry;
      req_is_kernel    <= kern;
      req_is_writeable <= wr;
      start_high = 1'b1;
      do @(posedge clock); while (busy);
      g = predict_grant(act, entry, kern, wr);
      pending_grants.push_back(g);
      tally[g.status]++;
      requests++;
      if (act == bfa_pkg::ACT_ALLOC && g.status == bfa_pkg::STAT_ALLOCATED && g.frame != '0)
      begin
         owned_frames.push_back(g.frame);
      end
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         start_high = 1'b0;
         start            <= 1'b0;
         req_entry_frame  <= bfa_pkg::FRAME_W'($urandom);
         req_is_kernel    <= 1'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            wait_results_drained();
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   // Write the limit only with the block idle.
   task automatic write_limit(logic [bfa_pkg::LIMIT_W-1:0] value);
      hold_sender();
      if (pending_grants.size() != 0) wait_results_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_data  <= bfa_pkg::LIMIT_W'($urandom);
      limit_model = value;
      limit_writes++;
      @(posedge clock);
   endtask

   task automatic test_first_fit_basics();
      issue(bfa_pkg::ACT_FREE, 12'h000, 1'b0, 1'b0);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b1, 1'b0);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b0, 1'b1);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b1, 1'b1);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b0, 1'b0);
      issue(bfa_pkg::ACT_ALLOC, 12'hFFF, 1'b1, 1'b1);
      issue(bfa_pkg::ACT_ALLOC, 12'h001, 1'b0, 1'b1);
      issue(bfa_pkg::ACT_ALLOC, 12'hAAA, 1'b0, 1'b0);
      issue(bfa_pkg::ACT_FREE, 12'hFFF, 1'b1, 1'b1);
      issue(bfa_pkg::ACT_FREE, 12'h555, 1'b0, 1'b1);
      issue(bfa_pkg::ACT_FREE, 12'h001, 1'b1, 1'b0);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b1, 1'b1);
      issue(bfa_pkg::ACT_FREE, 12'h800, 1'b0, 1'b0);
   endtask

   task automatic test_limit_extremes();
      write_limit(13'd0);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b0, 1'b1);
      write_limit(13'd31);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b1, 1'b0);
      issue(bfa_pkg::ACT_FREE, 12'h002, 1'b0, 1'b0);
      write_limit(13'd33);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b0, 1'b0);
      write_limit(13'd8191);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b1, 1'b1);
      issue(bfa_pkg::ACT_FREE, 12'h003, 1'b1, 1'b1);
      write_limit(13'd4096);
      issue(bfa_pkg::ACT_ALLOC, 12'h000, 1'b0, 1'b1);
   endtask

   // Mostly allocate/free pairs on owned frames, with held and stray frees mixed in.
   task automatic test_random_traffic(logic [bfa_pkg::LIMIT_W-1:0] limit, int count);
      int                          pick;
      int                          idx;
      logic [bfa_pkg::FRAME_W-1:0] frame;
      write_limit(limit);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            issue(bfa_pkg::ACT_ALLOC, '0, 1'($urandom), 1'($urandom));
         end else if (pick < 80 && owned_frames.size() != 0) begin
            idx   = $urandom_range(0, owned_frames.size() - 1);
            frame = owned_frames[idx];
            owned_frames.delete(idx);
            issue(bfa_pkg::ACT_FREE, frame, 1'($urandom), 1'($urandom));
         end else if (pick < 90) begin
            issue(bfa_pkg::ACT_ALLOC, bfa_pkg::FRAME_W'($urandom_range(1, 4095)),
                  1'($urandom), 1'($urandom));
         end else if (pick < 95) begin
            issue(bfa_pkg::ACT_FREE, '0, 1'($urandom), 1'($urandom));
         end else begin
            issue(bfa_pkg::ACT_FREE, bfa_pkg::FRAME_W'($urandom), 1'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= 1'b0;
      req_entry_frame  <= '0;
      req_is_kernel    <= 1'b0;
      req_is_writeable <= 1'b0;
      csr_valid        <= 1'b0;
      csr_data         <= '0;
      foreach (frame_map[i]) frame_map[i] = '0;
      limit_model = bfa_pkg::LIMIT_RESET;
      burst_left  = 4;
      start_high  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_first_fit_basics();
      test_limit_extremes();
      test_random_traffic(13'd32, 60);
      test_random_traffic(13'd64, 60);
      test_random_traffic(bfa_pkg::LIMIT_W'($urandom_range(0, 8191)), 50);
      test_random_traffic(bfa_pkg::LIMIT_W'($urandom_range(96, 127)), 60);
      test_random_traffic(13'd4096, 120);
      test_random_traffic(13'd8191, 100);

      hold_sender();
      if (pending_grants.size() != 0) wait_results_drained();
      repeat (10) @(posedge clock);

      $display("Ran %0d requests over %0d limit writes: %0d allocated, %0d held, %0d full.",
               requests, limit_writes, tally[bfa_pkg::STAT_ALLOCATED],
               tally[bfa_pkg::STAT_HELD], tally[bfa_pkg::STAT_NO_FREE]);
      $display("Frees: %0d cleared, %0d with no frame; %0d mismatches.",
               tally[bfa_pkg::STAT_FREED], tally[bfa_pkg::STAT_NONE], errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> bitmap_frame_allocator.f
+incdir+rtl/core
rtl/core/bfa_pkg.sv
rtl/core/bfa_map_store.sv
rtl/core/bitmap_frame_allocator.sv
dv/bitmap_frame_allocator_tb.sv
